[hw/rtl/fbtp_pkg.sv]
// fbtp_pkg: shared types, constants and helpers for the float byte truncate packer
// no dependencies; imported by every module of the block

package fbtp_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned WORD_BYTES    = 4;
    localparam int unsigned WORD_W        = BYTE_W * WORD_BYTES;
    localparam int unsigned PEND_W        = BYTE_W * (WORD_BYTES - 1);
    localparam int unsigned KBITS_W       = 6;
    localparam int unsigned KBYTES_W      = 3;
    localparam int unsigned CNT_W         = 2;
    localparam int unsigned OUT_DEPTH_DEF = 4;

    localparam logic [KBITS_W-1:0] KBITS_RESET = KBITS_W'(16);

    typedef struct packed {
        logic              last;
        logic [WORD_W-1:0] word;
    } t_out_entry;

    // results of one item: 0..2 words, first one in e0
    typedef struct packed {
        logic [1:0] num;
        t_out_entry e0;
        t_out_entry e1;
    } t_merge_res;

    // whole bytes kept per value, 1..4
    function automatic logic [KBYTES_W-1:0] bytes_kept(input logic [KBITS_W-1:0] bits);
        logic [KBITS_W-1:0] sum;
        sum = bits + KBITS_W'(BYTE_W - 1);
        if (bits == '0) begin
            bytes_kept = KBYTES_W'(1);
        end else if (bits > KBITS_W'(WORD_W)) begin
            bytes_kept = KBYTES_W'(WORD_BYTES);
        end else begin
            // bits is 1..32 here, so the sum stays below 40
            bytes_kept = sum[KBITS_W-1:3];
        end
    endfunction

endpackage

[hw/rtl/fbtp_merge.sv]
// fbtp_merge: byte truncation, merge with waiting bytes and word split
// depends on fbtp_pkg

module fbtp_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [fbtp_pkg::KBYTES_W-1:0] i_kept,
    input  logic [fbtp_pkg::WORD_W-1:0]   i_word,
    input  logic                          i_last,
    output fbtp_pkg::t_merge_res          o_res
);
    import fbtp_pkg::*;

    localparam int unsigned MERGE_W = WORD_W + PEND_W;

    logic [PEND_W-1:0]   r_pend_bytes;
    logic [CNT_W-1:0]    r_pend_count;
    logic [PEND_W-1:0]   n_pend_bytes;
    logic [CNT_W-1:0]    n_pend_count;

    logic [WORD_W-1:0]   kept;
    logic [MERGE_W-1:0]  merged;
    logic [KBYTES_W-1:0] total;
    logic [KBYTES_W-1:0] rem_total;
    logic                full;
    logic [MERGE_W-1:0]  rem;

    always_comb begin
        kept      = i_word >> {(KBYTES_W'(WORD_BYTES) - i_kept), 3'b000};
        merged    = {{WORD_W{1'b0}}, r_pend_bytes}
                  | ({{PEND_W{1'b0}}, kept} << {r_pend_count, 3'b000});
        total     = {1'b0, r_pend_count} + i_kept;
        full      = total[KBYTES_W-1];
        rem_total = full ? (total - KBYTES_W'(WORD_BYTES)) : total;
        rem       = full ? (merged >> WORD_W) : merged;

        o_res.e0.word = merged[WORD_W-1:0];
        o_res.e0.last = i_last && !(full && (rem_total != '0));
        o_res.e1.word = rem[WORD_W-1:0];
        o_res.e1.last = 1'b1;
        if (i_last) begin
            o_res.num = (full && (rem_total != '0)) ? 2'd2 : 2'd1;
        end else begin
            o_res.num = full ? 2'd1 : 2'd0;
        end

        if (i_last) begin
            n_pend_bytes = '0;
            n_pend_count = '0;
        end else begin
            n_pend_bytes = rem[PEND_W-1:0];
            n_pend_count = rem_total[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bytes <= '0;
            r_pend_count <= '0;
        end else if (i_advance) begin
            r_pend_bytes <= n_pend_bytes;
            r_pend_count <= n_pend_count;
        end
    end

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_last |=> r_pend_count == '0 && r_pend_bytes == '0)
        else $error("waiting bytes left after a flush");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_count == 2'd0 -> r_pend_bytes == '0)
        && (r_pend_count == 2'd1 -> r_pend_bytes[PEND_W-1:BYTE_W] == '0)
        && (r_pend_count == 2'd2 -> r_pend_bytes[PEND_W-1:2*BYTE_W] == '0))
        else $error("stale bytes above the waiting count");

endmodule

[hw/rtl/fbtp_out_fifo.sv]
// fbtp_out_fifo: small result queue taking up to two words per cycle
// depends on fbtp_pkg

module fbtp_out_fifo #(
    parameter int unsigned DEPTH = fbtp_pkg::OUT_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fbtp_pkg::t_merge_res        i_push,
    input  logic                        i_push_en,
    output logic                        o_room2,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fbtp_pkg::WORD_W-1:0] o_word,
    output logic                        o_last
);
    import fbtp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    t_out_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CW-1:0]    r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CW-1:0]    n_count;
    logic [PTR_W-1:0] wr_next;
    logic [1:0]       num;
    logic             pop;
    logic [CW-1:0]    after_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        num       = i_push_en ? i_push.num : 2'd0;
        pop       = o_valid && i_ready;
        after_pop = r_count - CW'(pop);
        o_room2   = after_pop <= CW'(DEPTH - 2);
        wr_next   = ptr_inc(r_wr);
        n_rd      = pop ? ptr_inc(r_rd) : r_rd;
        unique case (num)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = ptr_inc(wr_next);
            default: n_wr = r_wr;
        endcase
        n_count   = after_pop + CW'(num);
    end

    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd].word;
    assign o_last  = r_mem[r_rd].last;

    always_ff @(posedge i_clk) begin
        if (num != 2'd0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (num == 2'd2) begin
            r_mem[wr_next] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_en |-> after_pop + CW'(num) <= CW'(DEPTH))
        else $error("push into a queue without room");

endmodule

[hw/rtl/float_byte_truncate_packer_core.sv]
// float_byte_truncate_packer_core: top level of the float byte truncate packer
// depends on fbtp_pkg, fbtp_merge and fbtp_out_fifo

// Packs 32-bit float bit patterns into a dense byte stream. Each value keeps
// its top ceil(kept_bits/8) bytes (kept_bits 0 acts as 1, above 32 as 32),
// appended low kept byte first; the stream leaves as 32-bit words with the
// earliest byte in bits 7:0. A transfer with s_axis_tlast flushes any partial
// word padded with zero bytes and marks the final word with m_axis_tlast.
// Rate: one input transfer per cycle sustained while the output side takes a
// word per cycle. An accepted value sits in the input register, is merged with
// up to three waiting bytes in one pass and lands in a four-entry result queue;
// the first resulting word is registered into the queue when the held value
// advances and is offered from the queue head. A final value may yield two words,
// drained one per cycle while the consumer is ready; the input register only
// advances when the queue has room for two words, so a slow consumer stalls
// the input side as soon as three words wait and none leaves.
// kept_bits is written through the cfg channel (always ready) and must only
// change while the block holds no unfinished value.

module float_byte_truncate_packer_core #(
    parameter int unsigned OUT_DEPTH = fbtp_pkg::OUT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fbtp_pkg::KBITS_W-1:0]   i_cfg_data,   // kept_bits
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fbtp_pkg::WORD_W-1:0]    s_axis_tdata, // float_word
    input  logic                           s_axis_tlast, // is_last
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fbtp_pkg::WORD_W-1:0]    m_axis_tdata, // packed_word
    output logic                           m_axis_tlast  // last_word
);
    import fbtp_pkg::*;

    // precision register
    logic [KBITS_W-1:0]  r_kept_bits;
    // input register
    logic                r_in_valid;
    logic [WORD_W-1:0]   r_in_word;
    logic                r_in_last;

    logic                advance;
    logic                room2;
    logic                in_xfer;
    logic [KBYTES_W-1:0] kept_bytes;
    t_merge_res          res;

    assign o_cfg_ready   = 1'b1;
    assign kept_bytes    = bytes_kept(r_kept_bits);

    // the held value moves into the queue only if two words fit
    assign advance       = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_bits <= KBITS_RESET;
            r_in_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_kept_bits <= i_cfg_data;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_word <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    fbtp_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_kept    (kept_bytes),
        .i_word    (r_in_word),
        .i_last    (r_in_last),
        .o_res     (res)
    );

    fbtp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res),
        .i_push_en (advance),
        .o_room2   (room2),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_word    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

    // a held value is never lost: it either advances or is still held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("held input value dropped");

    // a final value always produces at least one word
    a_last_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |-> res.num != 2'd0 && (res.num == 2'd2 || res.e0.last))
        else $error("final value without a marked word");

endmodule
